### hdl/smd_pkg.sv
// Shared widths, types and split-multiplier helpers for the segment distance core.
// No dependencies; imported by every module of the block.
`default_nettype none

package smd_pkg;

    localparam int COORD_W   = 16;
    localparam int N_COORDS  = 12;
    localparam int IN_W      = COORD_W * N_COORDS;
    localparam int FRAC_BITS = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int DOT_W     = PROD_W + 2;
    localparam int HALF_W    = DOT_W / 2;
    localparam int MUL_W     = 2 * DOT_W;
    localparam int DIV_D_W   = MUL_W - 2;
    localparam int DIV_N_W   = DIV_D_W + 1;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int DIST_W    = 17;
    localparam int ROOT_W    = MUL_W / 2 + 1;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int SQ_W      = MUL_W + 2;
    localparam int OUT_W     = 24;

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PROD_W:0]   sprod_t;
    typedef logic signed [DOT_W-1:0]  dot_t;
    typedef logic signed [MUL_W-1:0]  wide_t;

    typedef struct packed {
        logic [2:0][DIFF_W-1:0] u;
        logic [2:0][DIFF_W-1:0] v;
        logic [2:0][DIFF_W-1:0] w;
    } uvw_t;

    // partial products of a 36x36 signed multiply, low halves unsigned
    typedef struct packed {
        logic signed [2*HALF_W:0] hh;
        logic signed [2*HALF_W:0] hl;
        logic signed [2*HALF_W:0] lh;
        logic [2*HALF_W-1:0]      ll;
    } pp_t;

    function automatic pp_t mul_part(input dot_t x, input dot_t y);
        logic signed [HALF_W-1:0] xh;
        logic signed [HALF_W-1:0] yh;
        logic signed [HALF_W:0]   xl;
        logic signed [HALF_W:0]   yl;
        pp_t p;
        xh   = x[DOT_W-1:HALF_W];
        yh   = y[DOT_W-1:HALF_W];
        xl   = {1'b0, x[HALF_W-1:0]};
        yl   = {1'b0, y[HALF_W-1:0]};
        p.hh = xh * yh;
        p.hl = xh * yl;
        p.lh = xl * yh;
        p.ll = x[HALF_W-1:0] * y[HALF_W-1:0];
        return p;
    endfunction

    function automatic wide_t mul_sum(input pp_t p);
        wide_t hh;
        wide_t mid;
        wide_t ll;
        hh  = wide_t'(p.hh);
        mid = wide_t'(p.hl) + wide_t'(p.lh);
        ll  = wide_t'(p.ll);
        return (hh <<< (2 * HALF_W)) + (mid <<< HALF_W) + ll;
    endfunction

endpackage

`default_nettype wire

### hdl/segment_segment_min_distance_core.sv
// Least distance between two 3-D segments (clamped closest-point method), fully pipelined.
// Depends on smd_pkg, smd_div and smd_sqrt.
//
//  channel | dir | fields
//  s_*     | in  | tdata: a_start xyz, a_end xyz, b_start xyz, b_end xyz (12 x 16b signed)
//  m_*     | out | tdata: distance (17b unsigned integer, Q17.0), touching (1b), zero pad
//
// One item per cycle while not stalled; the pipeline holds the 17-stage divider
// and the 37-stage square root. rst_n clears only the valid bits. When the output
// item is held by m_tready low the whole pipeline freezes and s_tready drops.
`default_nettype none

module segment_segment_min_distance_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
    // b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z
    input  logic [smd_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // distance[16:0], touching[17], zeros[23:18]
    output logic [smd_pkg::OUT_W-1:0]  m_tdata
);
    import smd_pkg::*;

    localparam int S8_IDX  = 7;
    localparam int DIV_OUT = S8_IDX + DIV_STEPS;
    localparam int P5_IDX  = DIV_OUT + 5;
    localparam int NSTG    = P5_IDX + SQ_STEPS + 1;

    logic             en;
    logic [NSTG-1:0]  vld_reg;
    logic [NSTG-1:0]  vld_next;

    logic signed [COORD_W-1:0] crd [N_COORDS];
    uvw_t  uvw_next;
    uvw_t  uvw_reg [DIV_OUT+1];

    prod_t uu_reg [3];
    prod_t uv_reg [3];
    prod_t vv_reg [3];
    prod_t uw_reg [3];
    prod_t vw_reg [3];

    dot_t  a3_next, b3_next, c3_next, d3_next, e3_next;
    dot_t  a3_reg, b3_reg, c3_reg, d3_reg, e3_reg;
    pp_t   ac4_reg, bb4_reg, be4_reg, cd4_reg, ae4_reg, bd4_reg;
    dot_t  a4_reg, b4_reg, c4_reg, d4_reg, e4_reg;
    wide_t ac5_reg, bb5_reg, be5_reg, cd5_reg, ae5_reg, bd5_reg;
    dot_t  a5_reg, b5_reg, c5_reg, d5_reg, e5_reg;
    wide_t dd6_reg, sn6_reg, tn6_reg;
    dot_t  a6_reg, c6_reg, e6_reg, eb6_reg, nd6_reg, bd6_reg;
    wide_t sn7_next, sd7_next, tn7_next, td7_next;
    wide_t sn7_reg, sd7_reg, tn7_reg, td7_reg;
    dot_t  a7_reg, nd7_reg, bd7_reg;
    wide_t sn8_next, sd8_next, tn8_next, td8_next;
    wide_t sn8_reg, sd8_reg, tn8_reg, td8_reg;
    dot_t  edge_num;
    logic  edge_hit;

    logic [Q_W-1:0] sq;
    logic [Q_W-1:0] tq;

    sprod_t us_reg [3];
    sprod_t vt_reg [3];
    diff_t  ws_reg [3];
    dot_t   comp_reg [3];
    pp_t    sqp_reg [3];
    wide_t  sqv_reg [3];
    wide_t  sum_next;
    wide_t  sum_reg;
    logic   z_reg [SQ_STEPS+1];

    logic [ROOT_W-1:0] root;

    assign en       = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NSTG-1];
    assign vld_next = {vld_reg[NSTG-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_comb
    begin
        for (int k = 0; k < N_COORDS; k++)
            crd[k] = s_tdata[k*COORD_W +: COORD_W];
        for (int i = 0; i < 3; i++)
        begin
            uvw_next.u[i] = DIFF_W'(crd[3+i]) - DIFF_W'(crd[i]);
            uvw_next.v[i] = DIFF_W'(crd[9+i]) - DIFF_W'(crd[6+i]);
            uvw_next.w[i] = DIFF_W'(crd[i])   - DIFF_W'(crd[6+i]);
        end
    end

    always_comb
    begin
        a3_next = '0;
        b3_next = '0;
        c3_next = '0;
        d3_next = '0;
        e3_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            a3_next = a3_next + dot_t'(uu_reg[i]);
            b3_next = b3_next + dot_t'(uv_reg[i]);
            c3_next = c3_next + dot_t'(vv_reg[i]);
            d3_next = d3_next + dot_t'(uw_reg[i]);
            e3_next = e3_next + dot_t'(vw_reg[i]);
        end
    end

    // first clamp: s from the unconstrained solution clamped to [0,1], or start of A when parallel
    always_comb
    begin
        if (dd6_reg <= 0)
        begin
            sn7_next = '0;
            sd7_next = wide_t'(1);
            tn7_next = wide_t'(e6_reg);
            td7_next = wide_t'(c6_reg);
        end
        else
        begin
            sn7_next = sn6_reg;
            sd7_next = dd6_reg;
            tn7_next = tn6_reg;
            td7_next = dd6_reg;
            if (sn6_reg < 0)
            begin
                sn7_next = '0;
                tn7_next = wide_t'(e6_reg);
                td7_next = wide_t'(c6_reg);
            end
            else if (sn6_reg > dd6_reg)
            begin
                sn7_next = dd6_reg;
                tn7_next = wide_t'(eb6_reg);
                td7_next = wide_t'(c6_reg);
            end
        end
    end

    // second clamp: t to its ends, s recomputed on that edge
    always_comb
    begin
        sn8_next = sn7_reg;
        sd8_next = sd7_reg;
        tn8_next = tn7_reg;
        td8_next = td7_reg;
        edge_num = nd7_reg;
        edge_hit = 1'b0;
        if (tn7_reg < 0)
        begin
            tn8_next = '0;
            edge_hit = 1'b1;
        end
        else if (tn7_reg > td7_reg)
        begin
            tn8_next = td7_reg;
            edge_num = bd7_reg;
            edge_hit = 1'b1;
        end
        if (edge_hit)
        begin
            if (edge_num < 0)
                sn8_next = '0;
            else if (edge_num > a7_reg)
                sn8_next = sd7_reg;
            else
            begin
                sn8_next = wide_t'(edge_num);
                sd8_next = wide_t'(a7_reg);
            end
        end
    end

    always_comb
    begin
        sum_next = sqv_reg[0] + sqv_reg[1] + sqv_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uvw_reg[0] <= uvw_next;
            for (int k = 1; k <= DIV_OUT; k++)
                uvw_reg[k] <= uvw_reg[k-1];

            for (int i = 0; i < 3; i++)
            begin
                uu_reg[i] <= $signed(uvw_reg[0].u[i]) * $signed(uvw_reg[0].u[i]);
                uv_reg[i] <= $signed(uvw_reg[0].u[i]) * $signed(uvw_reg[0].v[i]);
                vv_reg[i] <= $signed(uvw_reg[0].v[i]) * $signed(uvw_reg[0].v[i]);
                uw_reg[i] <= $signed(uvw_reg[0].u[i]) * $signed(uvw_reg[0].w[i]);
                vw_reg[i] <= $signed(uvw_reg[0].v[i]) * $signed(uvw_reg[0].w[i]);
            end

            a3_reg <= a3_next;
            b3_reg <= b3_next;
            c3_reg <= c3_next;
            d3_reg <= d3_next;
            e3_reg <= e3_next;

            ac4_reg <= mul_part(a3_reg, c3_reg);
            bb4_reg <= mul_part(b3_reg, b3_reg);
            be4_reg <= mul_part(b3_reg, e3_reg);
            cd4_reg <= mul_part(c3_reg, d3_reg);
            ae4_reg <= mul_part(a3_reg, e3_reg);
            bd4_reg <= mul_part(b3_reg, d3_reg);
            a4_reg  <= a3_reg;
            b4_reg  <= b3_reg;
            c4_reg  <= c3_reg;
            d4_reg  <= d3_reg;
            e4_reg  <= e3_reg;

            ac5_reg <= mul_sum(ac4_reg);
            bb5_reg <= mul_sum(bb4_reg);
            be5_reg <= mul_sum(be4_reg);
            cd5_reg <= mul_sum(cd4_reg);
            ae5_reg <= mul_sum(ae4_reg);
            bd5_reg <= mul_sum(bd4_reg);
            a5_reg  <= a4_reg;
            b5_reg  <= b4_reg;
            c5_reg  <= c4_reg;
            d5_reg  <= d4_reg;
            e5_reg  <= e4_reg;

            dd6_reg <= ac5_reg - bb5_reg;
            sn6_reg <= be5_reg - cd5_reg;
            tn6_reg <= ae5_reg - bd5_reg;
            a6_reg  <= a5_reg;
            c6_reg  <= c5_reg;
            e6_reg  <= e5_reg;
            eb6_reg <= e5_reg + b5_reg;
            nd6_reg <= -d5_reg;
            bd6_reg <= b5_reg - d5_reg;

            sn7_reg <= sn7_next;
            sd7_reg <= sd7_next;
            tn7_reg <= tn7_next;
            td7_reg <= td7_next;
            a7_reg  <= a6_reg;
            nd7_reg <= nd6_reg;
            bd7_reg <= bd6_reg;

            sn8_reg <= sn8_next;
            sd8_reg <= sd8_next;
            tn8_reg <= tn8_next;
            td8_reg <= td8_next;

            for (int i = 0; i < 3; i++)
            begin
                us_reg[i]   <= $signed(uvw_reg[DIV_OUT].u[i]) * $signed({1'b0, sq});
                vt_reg[i]   <= $signed(uvw_reg[DIV_OUT].v[i]) * $signed({1'b0, tq});
                ws_reg[i]   <= $signed(uvw_reg[DIV_OUT].w[i]);
                comp_reg[i] <= (dot_t'(ws_reg[i]) <<< FRAC_BITS) + dot_t'(us_reg[i])
                               - dot_t'(vt_reg[i]);
                sqp_reg[i]  <= mul_part(comp_reg[i], comp_reg[i]);
                sqv_reg[i]  <= mul_sum(sqp_reg[i]);
            end

            sum_reg  <= sum_next;
            z_reg[0] <= (sum_next == '0);
            for (int k = 1; k <= SQ_STEPS; k++)
                z_reg[k] <= z_reg[k-1];
        end
    end

    smd_div u_div_s (
        .clk (clk),
        .en  (en),
        .num (sn8_reg[DIV_D_W-1:0]),
        .den (sd8_reg[DIV_D_W-1:0]),
        .quo (sq)
    );

    smd_div u_div_t (
        .clk (clk),
        .en  (en),
        .num (tn8_reg[DIV_D_W-1:0]),
        .den (td8_reg[DIV_D_W-1:0]),
        .quo (tq)
    );

    smd_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (sum_reg[MUL_W-1:0]),
        .root (root)
    );

    assign m_tdata = {(OUT_W-DIST_W-1)'(0), z_reg[SQ_STEPS], root[FRAC_BITS +: DIST_W]};

    a_touch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[DIST_W] |-> m_tdata[DIST_W-1:0] == '0)
        else $error("touching set with nonzero distance");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S8_IDX] |-> sn8_reg >= 0 && sn8_reg <= sd8_reg
                            && tn8_reg >= 0 && tn8_reg <= td8_reg)
        else $error("parameter fraction out of range");

    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_OUT] |-> sq <= (Q_W'(1) << FRAC_BITS) && tq <= (Q_W'(1) << FRAC_BITS))
        else $error("quotient above one");

    a_norms: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> !a3_reg[DOT_W-1] && !c3_reg[DOT_W-1])
        else $error("negative squared length");

endmodule

`default_nettype wire

### hdl/smd_div.sv
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den), one quotient bit per stage.
// Depends on smd_pkg. Caller guarantees num <= den; den of zero reads as one.
`default_nettype none

module smd_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [smd_pkg::DIV_D_W-1:0] num,
    input  logic [smd_pkg::DIV_D_W-1:0] den,
    output logic [smd_pkg::Q_W-1:0]     quo
);
    import smd_pkg::*;

    logic [DIV_N_W-1:0] n_reg [DIV_STEPS];
    logic [DIV_D_W-1:0] d_reg [DIV_STEPS];
    logic [Q_W-1:0]     q_reg [DIV_STEPS];

    genvar i;
    generate
        for (i = 0; i < DIV_STEPS; i++)
        begin : g_step
            logic [DIV_N_W-1:0] n_in;
            logic [DIV_D_W-1:0] d_in;
            logic [Q_W-1:0]     q_in;
            logic [DIV_N_W:0]   diff;
            logic               ge;
            logic [DIV_N_W-1:0] n_next;

            if (i == 0)
            begin : g_first
                always_comb
                begin
                    n_in = {1'b0, num};
                    d_in = (den == '0) ? DIV_D_W'(1) : den;
                    q_in = '0;
                end
            end
            else
            begin : g_rest
                always_comb
                begin
                    n_in = n_reg[i-1];
                    d_in = d_reg[i-1];
                    q_in = q_reg[i-1];
                end
            end

            always_comb
            begin
                diff   = {1'b0, n_in} - {2'b00, d_in};
                ge     = !diff[DIV_N_W];
                n_next = ge ? {diff[DIV_N_W-2:0], 1'b0} : {n_in[DIV_N_W-2:0], 1'b0};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[i] <= n_next;
                    d_reg[i] <= d_in;
                    q_reg[i] <= {q_in[Q_W-2:0], ge};
                end
            end
        end
    endgenerate

    assign quo = q_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

### hdl/smd_sqrt.sv
// Pipelined integer square root, one result bit per stage (digit-by-digit method).
// Depends on smd_pkg.
`default_nettype none

module smd_sqrt (
    input  logic                         clk,
    input  logic                         en,
    input  logic [smd_pkg::MUL_W-1:0]    rad,
    output logic [smd_pkg::ROOT_W-1:0]   root
);
    import smd_pkg::*;

    logic [SQ_W-1:0] r_reg [SQ_STEPS];
    logic [SQ_W-1:0] x_reg [SQ_STEPS];

    genvar i;
    generate
        for (i = 0; i < SQ_STEPS; i++)
        begin : g_step
            localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - i));
            logic [SQ_W-1:0] r_in;
            logic [SQ_W-1:0] x_in;
            logic [SQ_W-1:0] trial;
            logic            ge;

            if (i == 0)
            begin : g_first
                always_comb
                begin
                    r_in = {2'b00, rad};
                    x_in = '0;
                end
            end
            else
            begin : g_rest
                always_comb
                begin
                    r_in = r_reg[i-1];
                    x_in = x_reg[i-1];
                end
            end

            always_comb
            begin
                trial = x_in + BIT;
                ge    = (r_in >= trial);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[i] <= ge ? (r_in - trial) : r_in;
                    x_reg[i] <= ge ? ((x_in >> 1) + BIT) : (x_in >> 1);
                end
            end
        end
    endgenerate

    assign root = x_reg[SQ_STEPS-1][ROOT_W-1:0];

endmodule

`default_nettype wire
